@@ hw/rtl/tiled_canvas_pixel_plotter_unit_assert.svh @@
// Assertion macros for the tiled canvas pixel plotter checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef TILED_CANVAS_PIXEL_PLOTTER_UNIT_ASSERT_SVH
`define TILED_CANVAS_PIXEL_PLOTTER_UNIT_ASSERT_SVH

// same-cycle implication
`define TCPP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCPP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tcpp_pkg.sv @@
// Package for the tiled canvas pixel plotter: canvas geometry, codes and types.
// No dependencies.
package tcpp_pkg;

  localparam int WIDTH_TILES  = 14;
  localparam int HEIGHT_TILES = 10;

  localparam int TileTotal   = WIDTH_TILES * HEIGHT_TILES;
  localparam int RowTotal    = TileTotal * 8;
  localparam int CanvasBytes = TileTotal * 16;
  localparam int WidthPx     = WIDTH_TILES * 8;
  localparam int HeightPx    = HEIGHT_TILES * 8;
  localparam int RowW        = $clog2(RowTotal);
  localparam int TileW       = $clog2(TileTotal + 1);
  localparam int SumW        = $clog2(TileTotal + 17);
  localparam int MaxStep     = 16;

  localparam logic [15:0] FillWord = 16'hffff;
  localparam logic [7:0]  PixelMsb = 8'h80;

  typedef enum logic [1:0] {
    CFG_X_ORIGIN   = 2'd0,
    CFG_Y_ORIGIN   = 2'd1,
    CFG_SEC_SHADE  = 2'd2,
    CFG_CLEAR_STEP = 2'd3
  } cfg_idx_e;

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DECODE = 6'b000100,
    ST_RD     = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_FIN    = 6'b100000
  } state_e;

  typedef struct packed {
    logic       leave;
    logic       pix_chg;
    logic [7:0] chg_tile;
    logic       clr_start;
    logic [7:0] clr_first;
    logic [4:0] clr_cnt;
    logic       clr_fin;
    logic [1:0] shade;
    logic [7:0] rdata;
  } res_t;

endpackage

@@ hw/rtl/tcpp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcpp_ram #(
  parameter int Width = 16,
  parameter int Depth = 1120
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/tiled_canvas_pixel_plotter_unit.sv @@
// Tiled canvas pixel plotter top level: sequencer, config registers, canvas RAM.
// Depends on tcpp_pkg and tcpp_ram.
// Path from accept to result word: in-range reads and plots go DECODE, RD, FIN; other
// events DECODE, FIN; a clear step DECODE, FILL (one row word written per cycle
// through the single RAM port), FIN. One word in work at a time; the next is taken
// the cycle after the result is registered, and FIN waits while the output is stalled.
// Reset: a clearing pass writes all RowTotal canvas rows (1120 by default) to all
// ones, with input stalled; config writes are taken throughout.
module tiled_canvas_pixel_plotter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  pointer_x_i,
  input  logic [7:0]  pointer_y_i,
  input  logic        held_a_i,
  input  logic        held_b_i,
  input  logic        pressed_a_i,
  input  logic        pressed_b_i,
  input  logic        pressed_select_i,
  input  logic        pressed_start_i,
  input  logic [11:0] read_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        leave_app_o,
  output logic        pixel_changed_o,
  output logic [7:0]  changed_tile_o,
  output logic        clear_started_o,
  output logic [7:0]  clear_first_tile_o,
  output logic [4:0]  clear_tile_count_o,
  output logic        clear_finished_o,
  output logic [1:0]  primary_shade_now_o,
  output logic [7:0]  read_data_o
);
  import tcpp_pkg::*;

  state_e            state_q, state_d;
  logic [7:0]        xo_q, yo_q;
  logic [1:0]        sec_q;
  logic [4:0]        step_q;
  logic [1:0]        primary_q, primary_d;
  logic              busy_q, busy_d;
  logic [TileW-1:0]  next_q, next_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [RowW-1:0]   last_q, last_d;
  logic [1:0]        shade_q, shade_d;
  res_t              res_q, res_d;
  res_t              out_q;
  logic              out_valid_q;
  logic              out_load;

  logic              req_q, ha_q, hb_q, pa_q, pb_q, psel_q, pstart_q;
  logic [7:0]        px_q, py_q;
  logic [11:0]       addr_q;

  logic              in_acc;
  logic [7:0]        rx, ry;
  logic              in_x, in_y;
  logic [TileW-1:0]  tile_plot;
  logic [RowW-1:0]   row_plot, rd_row;
  logic [1:0]        prim_nxt;
  logic              addr_ok;
  logic [4:0]        n_req, n_eff;
  logic [SumW-1:0]   sum_req;
  logic [TileW-1:0]  end_tile;
  logic [7:0]        bit_mask, n0, n1;
  logic              pix_chg;

  logic              ram_we;
  logic [RowW-1:0]   ram_waddr;
  logic [15:0]       ram_wdata, ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xo_q   <= 8'd24;
      yo_q   <= 8'd32;
      sec_q  <= 2'd3;
      step_q <= 5'd4;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_X_ORIGIN:   xo_q   <= cfg_data_i;
        CFG_Y_ORIGIN:   yo_q   <= cfg_data_i;
        CFG_SEC_SHADE:  sec_q  <= cfg_data_i[1:0];
        CFG_CLEAR_STEP: step_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= req_type_i;
      px_q     <= pointer_x_i;
      py_q     <= pointer_y_i;
      ha_q     <= held_a_i;
      hb_q     <= held_b_i;
      pa_q     <= pressed_a_i;
      pb_q     <= pressed_b_i;
      psel_q   <= pressed_select_i;
      pstart_q <= pressed_start_i;
      addr_q   <= read_address_i;
    end
    res_q   <= res_d;
    last_q  <= last_d;
    shade_q <= shade_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      primary_q   <= 2'd0;
      busy_q      <= 1'b0;
      next_q      <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      primary_q <= primary_d;
      busy_q    <= busy_d;
      next_q    <= next_d;
      row_q     <= row_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pointer to canvas coordinates
  assign rx        = px_q - xo_q;
  assign ry        = py_q - yo_q;
  assign in_x      = (px_q >= xo_q) && ({1'b0, rx} < 9'(WidthPx));
  assign in_y      = (py_q >= yo_q) && ({1'b0, ry} < 9'(HeightPx));
  assign tile_plot = TileW'(ry[7:3]) * TileW'(WIDTH_TILES) + TileW'(rx[7:3]);
  assign row_plot  = RowW'({tile_plot, ry[2:0]});
  assign prim_nxt  = psel_q ? primary_q + 2'd1 : primary_q;
  assign addr_ok   = {1'b0, addr_q} < 13'(CanvasBytes);
  assign rd_row    = req_q ? RowW'(addr_q[11:1]) : row_plot;

  // clear step size
  always_comb begin
    if (step_q == 5'd0) begin
      n_req = 5'd1;
    end else if (step_q > 5'(MaxStep)) begin
      n_req = 5'(MaxStep);
    end else begin
      n_req = step_q;
    end
    sum_req = SumW'(next_q) + SumW'(n_req);
    if (next_q >= TileW'(TileTotal)) begin
      n_eff = 5'd0;
    end else if (sum_req > SumW'(TileTotal)) begin
      n_eff = 5'(SumW'(TileTotal) - SumW'(next_q));
    end else begin
      n_eff = n_req;
    end
    end_tile = TileW'(SumW'(next_q) + SumW'(n_eff));
  end

  // pixel update on the fetched row word, plane 0 in the low byte
  assign bit_mask = PixelMsb >> rx[2:0];
  assign n0       = (ram_rdata[7:0] & ~bit_mask) | (shade_q[0] ? bit_mask : 8'h00);
  assign n1       = (ram_rdata[15:8] & ~bit_mask) | (shade_q[1] ? bit_mask : 8'h00);
  assign pix_chg  = ({n1, n0} != ram_rdata);

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    last_d    = last_q;
    res_d     = res_q;
    primary_d = primary_q;
    busy_d    = busy_q;
    next_d    = next_q;
    shade_d   = shade_q;
    ram_we    = 1'b0;
    ram_waddr = row_q;
    ram_wdata = FillWord;
    out_load  = 1'b0;
    case (state_q)
      ST_INIT: begin
        ram_we = 1'b1;
        if (row_q == RowW'(RowTotal - 1)) begin
          row_d   = '0;
          state_d = ST_IDLE;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_d   = '0;
        state_d = ST_FIN;
        if (req_q) begin
          if (addr_ok) begin
            state_d = ST_RD;
          end
        end else if (pstart_q) begin
          res_d.leave = 1'b1;
        end else if (busy_q) begin
          res_d.clr_first = 8'(next_q);
          res_d.clr_cnt   = n_eff;
          row_d           = RowW'(next_q) << 3;
          last_d          = (RowW'(end_tile) << 3) - RowW'(1);
          next_d          = end_tile;
          if (end_tile >= TileW'(TileTotal)) begin
            busy_d        = 1'b0;
            res_d.clr_fin = 1'b1;
          end
          if (n_eff != 5'd0) begin
            state_d = ST_FILL;
          end
        end else if (ha_q && hb_q) begin
          if (pa_q || pb_q) begin
            busy_d          = 1'b1;
            next_d          = '0;
            res_d.clr_start = 1'b1;
          end
        end else begin
          primary_d = prim_nxt;
          if ((ha_q || hb_q) && in_x && in_y) begin
            shade_d = ha_q ? prim_nxt : sec_q;
            state_d = ST_RD;
          end
        end
        res_d.shade = primary_d;
      end
      ST_RD: begin
        state_d = ST_FIN;
        if (req_q) begin
          res_d.rdata = addr_q[0] ? ram_rdata[15:8] : ram_rdata[7:0];
        end else if (pix_chg) begin
          ram_we         = 1'b1;
          ram_waddr      = row_plot;
          ram_wdata      = {n1, n0};
          res_d.pix_chg  = 1'b1;
          res_d.chg_tile = 8'(tile_plot);
        end
      end
      ST_FILL: begin
        ram_we = 1'b1;
        if (row_q == last_q) begin
          state_d = ST_FIN;
        end else begin
          row_d = row_q + RowW'(1);
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  tcpp_ram #(
    .Width (16),
    .Depth (RowTotal)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_row),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o         = out_valid_q;
  assign leave_app_o         = out_q.leave;
  assign pixel_changed_o     = out_q.pix_chg;
  assign changed_tile_o      = out_q.chg_tile;
  assign clear_started_o     = out_q.clr_start;
  assign clear_first_tile_o  = out_q.clr_first;
  assign clear_tile_count_o  = out_q.clr_cnt;
  assign clear_finished_o    = out_q.clr_fin;
  assign primary_shade_now_o = out_q.shade;
  assign read_data_o         = out_q.rdata;

endmodule

@@ hw/rtl/tcpp_checker.sv @@
// Port-level checker for the tiled canvas pixel plotter, bound to the top level.
// Depends on tiled_canvas_pixel_plotter_unit_assert.svh.
`include "tiled_canvas_pixel_plotter_unit_assert.svh"

module tcpp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       leave_app_o,
  input logic       pixel_changed_o,
  input logic [7:0] changed_tile_o,
  input logic       clear_started_o,
  input logic [4:0] clear_tile_count_o,
  input logic [1:0] primary_shade_now_o,
  input logic [7:0] read_data_o
);

  `TCPP_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(read_data_o) && $stable(changed_tile_o) && $stable(primary_shade_now_o), "stalled word changed")
  `TCPP_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "word taken while busy")
  `TCPP_ASSERT_IMP(a_leave_alone, out_valid_o && leave_app_o, !pixel_changed_o && !clear_started_o && clear_tile_count_o == 5'd0 && read_data_o == 8'd0, "leave with side effects")
  `TCPP_ASSERT_IMP(a_tile_zero, out_valid_o && !pixel_changed_o, changed_tile_o == 8'd0, "tile without change")
  `TCPP_ASSERT_IMP(a_clear_count, out_valid_o, clear_tile_count_o <= 5'd16 && !(clear_started_o && clear_tile_count_o != 5'd0), "bad clear count")

endmodule

bind tiled_canvas_pixel_plotter_unit tcpp_checker u_tcpp_checker (.*);
